// File: rtl/core/mdet_pkg.sv
// Shared constants, permutation table and helper functions for the
// determinant block. No dependencies.
`timescale 1ns / 1ps

package mdet_pkg;

    localparam int MAX_ORDER_DEF     = 4;
    localparam int ELEMENT_WIDTH_DEF = 12;

    localparam int          CFG_ORDER_W  = 3;
    localparam logic [2:0]  ORDER_RESET  = 3'd4;

    localparam int FRAC_IN  = 8;
    localparam int FRAC_OUT = 32;
    localparam int DET_W    = 50;

    // Permutations of four columns. The first 1, 2 and 6 entries are
    // exactly the permutations of orders one, two and three.
    localparam int PERM_COUNT = 24;
    localparam int PERM_IDX_W = 5;
    localparam int PERM_ROW_W = 2;

    // Column for row r sits at bits [2r+1:2r].
    localparam logic [7:0] PERM_COL [PERM_COUNT] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd3, 2'd2, 2'd0, 2'd1},
        {2'd3, 2'd1, 2'd2, 2'd0}, {2'd3, 2'd0, 2'd2, 2'd1},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd3, 2'd0, 2'd1, 2'd2},
        {2'd2, 2'd3, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd2, 2'd1, 2'd3, 2'd0}, {2'd2, 2'd0, 2'd3, 2'd1},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
        {2'd1, 2'd3, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd0, 2'd2},
        {2'd1, 2'd2, 2'd3, 2'd0}, {2'd1, 2'd0, 2'd3, 2'd2},
        {2'd1, 2'd2, 2'd0, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3},
        {2'd0, 2'd3, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd0, 2'd2, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd1, 2'd3},
        {2'd0, 2'd1, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd2, 2'd3}
    };

    // Odd permutations.
    localparam logic [PERM_COUNT-1:0] PERM_NEG = 24'b0110_0110_0110_0110_0110_0110;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

    function automatic logic [PERM_IDX_W-1:0] perm_total(input logic [2:0] n);
        logic [PERM_IDX_W-1:0] f;
        case (n)
            3'd1:    f = 5'd1;
            3'd2:    f = 5'd2;
            3'd3:    f = 5'd6;
            default: f = 5'd24;
        endcase
        return f;
    endfunction

    // Left shift from Q(8n) product to 32 fraction bits.
    function automatic logic [4:0] out_shift(input logic [2:0] n);
        logic [4:0] s;
        case (n)
            3'd1:    s = 5'(FRAC_OUT - FRAC_IN);
            3'd2:    s = 5'(FRAC_OUT - 2 * FRAC_IN);
            3'd3:    s = 5'(FRAC_OUT - 3 * FRAC_IN);
            default: s = 5'(FRAC_OUT - 4 * FRAC_IN);
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/matrix_determinant_top.sv
// Determinant block top level: element load, order register, result
// register. Instantiates mdet_store and mdet_engine; uses mdet_pkg.
`timescale 1ns / 1ps

// Loads an n-by-n matrix (n = order register, 1..MAX_ORDER; 0 reads as 1,
// larger values saturate) one signed Q4.8 element per transfer, row-major,
// then returns its determinant as signed Q.32 in 50 bits. Elements load at
// one per cycle into the element store while s_ready is high. After the
// last element, the input side stalls while the engine walks the n!
// permutations of the columns, one store read per row, paced by the single
// read port of the store and the one multiplier. A finished result waits
// in the output register while loading of the next matrix goes on; only
// its last element waits for that register to empty. Writing the order
// restarts loading at element 0; write it only while the block is idle.
// No clearing pass follows reset.
module matrix_determinant_top import mdet_pkg::*; #(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [CFG_ORDER_W-1:0]          cfg_wr_data,
    // element channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [ELEMENT_WIDTH-1:0] s_element,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [DET_W-1:0]         m_determinant
);

    localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int SQ_W   = 2 * ORD_W;

    logic [CFG_ORDER_W-1:0] order_reg;
    logic [ADDR_W-1:0]      load_cnt_reg;
    logic                   m_valid_reg;
    logic signed [DET_W-1:0] m_det_reg;

    logic [ORD_W-1:0]  n_eff;
    logic [SQ_W-1:0]   n_sq;
    logic [ADDR_W-1:0] last_idx;
    logic              load_last;
    logic              s_xfer;
    logic              start;

    logic                            rd_en;
    logic [ADDR_W-1:0]               rd_addr;
    logic signed [ELEMENT_WIDTH-1:0] rd_data;
    logic signed [DET_W-1:0]         eng_det;
    eng_stat_t                       eng_stat;

    // Saturate the order into 1..MAX_ORDER.
    always_comb begin
        if (order_reg == '0) begin
            n_eff = ORD_W'(1);
        end else if (order_reg > CFG_ORDER_W'(MAX_ORDER)) begin
            n_eff = ORD_W'(MAX_ORDER);
        end else begin
            n_eff = order_reg[ORD_W-1:0];
        end
    end

    assign n_sq      = SQ_W'(n_eff) * SQ_W'(n_eff);
    assign last_idx  = ADDR_W'(n_sq - SQ_W'(1));
    assign load_last = (load_cnt_reg == last_idx);

    // Stall while computing; hold the last element until the result
    // register is free so the engine never finds it occupied.
    assign s_ready = !eng_stat.busy && !(m_valid_reg && load_last);
    assign s_xfer  = s_valid && s_ready;
    assign start   = s_xfer && load_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg    <= ORDER_RESET;
            load_cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            order_reg    <= cfg_wr_data;
            load_cnt_reg <= '0;
        end else if (s_xfer) begin
            load_cnt_reg <= load_last ? '0 : load_cnt_reg + 1'b1;
        end
    end

    mdet_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (ELEMENT_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_xfer),
        .wr_addr (load_cnt_reg),
        .wr_data (s_element),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mdet_engine #(
        .MAX_ORDER     (MAX_ORDER),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .ORD_W         (ORD_W),
        .ADDR_W        (ADDR_W)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .order_n (n_eff),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .det     (eng_det),
        .stat    (eng_stat)
    );

    // Output register: loaded when the engine finishes, cleared on transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_stat.done) begin
            m_det_reg <= eng_det;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_determinant = m_det_reg;

    // The store is never written while the engine reads it.
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> !eng_stat.busy)
        else $error("element transfer during compute");

    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.done |-> !m_valid_reg)
        else $error("result register still occupied at engine finish");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> eng_stat.busy)
        else $error("engine did not start after last element");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> load_cnt_reg == '0)
        else $error("order write did not restart loading");

endmodule

// File: rtl/core/mdet_store.sv
// Matrix element store: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module mdet_store #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 12,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mdet_engine.sv
// Permutation-product sequencer: reads the store row by row, multiplies,
// accumulates signed products and scales the sum. Depends on mdet_pkg.
`timescale 1ns / 1ps

module mdet_engine import mdet_pkg::*; #(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int ORD_W         = 3,
    parameter int ADDR_W        = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ORD_W-1:0]          order_n,
    output logic                      rd_en,
    output logic [ADDR_W-1:0]         rd_addr,
    input  logic signed [ELEMENT_WIDTH-1:0] rd_data,
    output logic signed [DET_W-1:0]   det,
    output eng_stat_t                 stat
);

    localparam int PROD_W = ELEMENT_WIDTH * MAX_ORDER;
    localparam int MUL_W  = PROD_W + ELEMENT_WIDTH;
    localparam int ACC_W  = PROD_W + 5;
    localparam int EXT_W  = ACC_W + FRAC_OUT;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg;
    logic [ORD_W-1:0]      n_reg;
    logic [PERM_IDX_W-1:0] perm_reg;
    logic [PERM_ROW_W-1:0] row_reg;

    logic rd_valid_reg, rd_first_reg, rd_last_reg, rd_neg_reg;
    logic add_pend_reg, add_neg_reg;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DET_W-1:0]  det_reg, det_next;

    logic                 row_last, perm_last, pipe_empty;
    logic [1:0]           col;
    logic [4:0]           addr_full;
    logic signed [MUL_W-1:0] mul_full;
    logic signed [EXT_W-1:0] acc_ext, acc_shifted;

    assign row_last   = ({1'b0, row_reg} == (3'(n_reg) - 3'd1));
    assign perm_last  = (perm_reg == (perm_total(3'(n_reg)) - 5'd1));
    assign pipe_empty = !rd_valid_reg && !add_pend_reg;

    // Store address of (row, column of this permutation).
    assign col       = PERM_COL[perm_reg][2*row_reg +: 2];
    assign addr_full = 5'(row_reg) * 5'(n_reg) + 5'(col);
    assign rd_addr   = addr_full[ADDR_W-1:0];
    assign rd_en     = (state_reg == ST_RUN);

    assign mul_full  = prod_reg * rd_data;
    assign prod_next = rd_first_reg ? PROD_W'(rd_data) : mul_full[PROD_W-1:0];
    assign acc_next  = add_neg_reg ? acc_reg - ACC_W'(prod_reg)
                                   : acc_reg + ACC_W'(prod_reg);

    assign acc_ext     = EXT_W'(acc_reg);
    assign acc_shifted = acc_ext <<< out_shift(3'(n_reg));
    assign det_next    = acc_shifted[DET_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            perm_reg     <= '0;
            row_reg      <= '0;
            rd_valid_reg <= 1'b0;
            add_pend_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_RUN);
            add_pend_reg <= rd_valid_reg && rd_last_reg;
            case (state_reg)
                ST_IDLE: begin
                    perm_reg <= '0;
                    row_reg  <= '0;
                    if (start) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (row_last) begin
                        row_reg  <= '0;
                        perm_reg <= perm_reg + 1'b1;
                        if (perm_last) begin
                            state_reg <= ST_DRAIN;
                        end
                    end else begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            n_reg   <= order_n;
            acc_reg <= '0;
        end else if (add_pend_reg) begin
            acc_reg <= acc_next;
        end
        rd_first_reg <= (row_reg == '0);
        rd_last_reg  <= row_last;
        rd_neg_reg   <= PERM_NEG[perm_reg];
        if (rd_valid_reg) begin
            prod_reg    <= prod_next;
            add_neg_reg <= rd_neg_reg;
        end
        if (state_reg == ST_DRAIN && pipe_empty) begin
            det_reg <= det_next;
        end
    end

    assign det       = det_reg;
    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == ST_IDLE)
        else $error("start while engine busy");

    a_no_read_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> !rd_valid_reg && !add_pend_reg)
        else $error("result taken before pipeline drained");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> state_reg == ST_IDLE)
        else $error("done lasted more than one cycle");

endmodule

// File: dv/matrix_determinant_checker.sv
`timescale 1ns / 1ps
// Determinant checker: follows order writes and element transfers, predicts
// each determinant and compares it with the result channel.
// Depends on mdet_pkg.

module matrix_determinant_checker import mdet_pkg::*; #(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [CFG_ORDER_W-1:0]          cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic signed [ELEMENT_WIDTH-1:0] s_element,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [DET_W-1:0]         m_determinant,
    output int                              fail_count,
    output int                              outstanding
);

    localparam int STORE_DEPTH = 16;

    logic [CFG_ORDER_W-1:0]  order_reg;
    int                      loaded;
    int                      result_index;
    longint                  element_store [STORE_DEPTH];
    logic signed [DET_W-1:0] det_queue [$];

    // 0 reads as 1, anything above the maximum saturates
    function automatic int active_order(input logic [CFG_ORDER_W-1:0] value);
        if (value == '0)
            return 1;
        if (int'(value) > MAX_ORDER)
            return MAX_ORDER;
        return int'(value);
    endfunction

    // Signed sum over all column permutations; parity from inversion count.
    function automatic longint permutation_sum(input int n);
        longint total;
        longint prod;
        int     col [4];
        int     tuple;
        int     r;
        int     k;
        int     inversions;
        bit     distinct;
        total = 0;
        for (tuple = 0; tuple < (1 << (2 * n)); tuple++) begin
            for (r = 0; r < n; r++)
                col[r] = (tuple >> (2 * r)) & 3;
            distinct   = 1'b1;
            inversions = 0;
            for (r = 0; r < n; r++) begin
                if (col[r] >= n)
                    distinct = 1'b0;
                for (k = r + 1; k < n; k++) begin
                    if (col[k] == col[r])
                        distinct = 1'b0;
                    if (col[k] < col[r])
                        inversions++;
                end
            end
            if (distinct) begin
                prod = 1;
                for (r = 0; r < n; r++)
                    prod = prod * element_store[r * n + col[r]];
                total = (inversions % 2 == 1) ? total - prod : total + prod;
            end
        end
        return total;
    endfunction

    // Q(8n) sum to Q.32, truncated to the port width
    function automatic logic signed [DET_W-1:0] to_q32(input longint det, input int n);
        longint wide;
        wide = det <<< (FRAC_OUT - FRAC_IN * n);
        return wide[DET_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] determinant check: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin : track
        int                      n;
        logic signed [DET_W-1:0] want;
        if (!aresetn) begin
            order_reg    = ORDER_RESET;
            loaded       = 0;
            result_index = 0;
            det_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (det_queue.size() == 0) begin
                    report_mismatch($sformatf("result %0d (%0d) with nothing expected",
                                              result_index, m_determinant));
                end else begin
                    want = det_queue.pop_front();
                    if (m_determinant !== want)
                        report_mismatch($sformatf("result %0d: got %0d, expected %0d",
                                                  result_index, m_determinant, want));
                end
                result_index++;
            end
            if (cfg_wr_en) begin
                order_reg = cfg_wr_data;
                loaded    = 0;
            end
            if (s_valid && s_ready) begin
                n = active_order(order_reg);
                if (loaded >= n * n)
                    loaded = 0;
                element_store[loaded % STORE_DEPTH] = longint'(s_element);
                loaded++;
                if (loaded == n * n) begin
                    loaded = 0;
                    det_queue.push_back(to_q32(permutation_sum(n), n));
                end
            end
        end
        outstanding <= det_queue.size();
    end

endmodule

// File: dv/matrix_determinant_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for matrix_determinant_top: element and order stimulus,
// result-side back-pressure, run limit and verdict.
// Depends on mdet_pkg, matrix_determinant_top and matrix_determinant_checker.

module matrix_determinant_top_tb;
    import mdet_pkg::*;

    localparam int ELEM_W        = ELEMENT_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 1050;
    // settle wait: the order-four compute phase, plus margin
    localparam int SETTLE_CYCLES = 110;
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};

    logic                     aclk;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [CFG_ORDER_W-1:0]   cfg_wr_data = '0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic signed [ELEM_W-1:0] s_element   = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic signed [DET_W-1:0]  m_determinant;

    int fail_count;
    int outstanding;
    int items_sent   = 0;
    int cycle_count  = 0;
    bit sender_calm  = 1'b0;
    int ready_stall  = 0;
    int ready_calm   = 0;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    matrix_determinant_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_element     (s_element),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_determinant (m_determinant)
    );

    // Checker sits beside the block; it owns prediction and comparison and
    // only hands back how many results are still due and how many failed.
    matrix_determinant_checker det_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_element     (s_element),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_determinant (m_determinant),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Hard stop: a run that reaches the cycle limit fails.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result-side pacing. Mostly ready with short stalls, now and then a
    // long stall, and calm stretches where ready simply stays high.
    always @(posedge aclk) begin : result_pacing
        int pick;
        if (ready_calm > 0) begin
            m_ready <= 1'b1;
            ready_calm--;
        end else if (ready_stall > 0) begin
            m_ready <= 1'b0;
            ready_stall--;
        end else begin
            m_ready <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 3)
                ready_calm = $urandom_range(200, 20);
            else if (pick < 25)
                ready_stall = $urandom_range(3, 1);
            else if (pick < 28)
                ready_stall = $urandom_range(40, 8);
        end
    end

    // Same mapping the block applies to the order register.
    function automatic int matrix_order(input logic [CFG_ORDER_W-1:0] value);
        if (value == '0)
            return 1;
        if (int'(value) > MAX_ORDER_DEF)
            return MAX_ORDER_DEF;
        return int'(value);
    endfunction

    // First eight random phases sweep every register value, orders one and four first.
    function automatic logic [CFG_ORDER_W-1:0] sweep_order(input int phase);
        case (phase)
            0:       return 3'd1;
            1:       return 3'd4;
            2:       return 3'd3;
            3:       return 3'd2;
            4:       return 3'd5;
            5:       return 3'd0;
            6:       return 3'd6;
            default: return 3'd7;
        endcase
    endfunction

    // Idle cycles before the next element transfer.
    function automatic int sender_gap();
        int pick;
        if (sender_calm)
            return 0;
        pick = $urandom_range(99);
        if (pick < 70)
            return 0;
        if (pick < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Full-range values dominate; extremes and small magnitudes mixed in.
    function automatic logic signed [ELEM_W-1:0] random_element();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            case ($urandom_range(4))
                0:       return ELEM_MAX;
                1:       return ELEM_MIN;
                2:       return '0;
                3:       return '1;
                default: return ELEM_W'(1);
            endcase
        end
        if (pick < 30)
            return ELEM_W'(int'($urandom_range(1023)) - 512);
        return ELEM_W'($urandom);
    endfunction

    // One element transfer. Valid is only dropped when a gap follows, so
    // back-to-back transfers never see two assignments to s_valid in a step.
    task automatic send_element(input logic signed [ELEM_W-1:0] value);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_element <= value;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    task automatic send_matrix(input int n);
        int i;
        for (i = 0; i < n * n; i++)
            send_element(random_element());
    endtask

    // Sender holds off until every predicted determinant has come back.
    // The wait before the first check lets the checker count a matrix finished just now.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Order writes go in only with the block idle: results drained, then a
    // compute-phase worth of cycles in case a load was left half done.
    task automatic program_order(input logic [CFG_ORDER_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int                     phase;
        int                     n;
        int                     matrices;
        int                     i;
        int                     random_start;
        logic [CFG_ORDER_W-1:0] value;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        // Partial load at the reset order (four); the order write that
        // follows must throw it away and restart at element zero.
        for (i = 0; i < 3; i++)
            send_element(random_element());

        // Register value zero reads as order one: each element is a result.
        program_order(3'd0);
        send_element(ELEM_MIN);
        send_element(ELEM_MAX);

        // Order two with extreme corners.
        program_order(3'd2);
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(ELEM_MIN);
        send_element(ELEM_MAX);

        // Top register value saturates to order four; extreme diagonal over
        // an extreme negative background gives a negative result of near-largest magnitude.
        program_order(3'd7);
        for (i = 0; i < 16; i++)
            send_element((i / 4 == i % 4) ? ELEM_MAX : ELEM_MIN);

        // Random part: phases of one order setting each, whole matrices with
        // random content, occasional drain pauses and abandoned loads.
        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (phase < 8)
                value = sweep_order(phase);
            else if ($urandom_range(9) < 2)
                value = CFG_ORDER_W'($urandom_range(7));
            else
                value = CFG_ORDER_W'($urandom_range(4, 1));
            program_order(value);
            n           = matrix_order(value);
            sender_calm = ($urandom_range(3) == 0);
            matrices    = $urandom_range(48 / (n * n) + 1, 1);
            for (i = 0; i < matrices; i++) begin
                send_matrix(n);
                if ($urandom_range(11) == 0)
                    drain_results();
            end
            // broken sequence: the next order write discards it
            if (n > 1 && $urandom_range(3) == 0) begin
                matrices = $urandom_range(n * n - 1, 1);
                for (i = 0; i < matrices; i++)
                    send_element(random_element());
            end
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mdet_pkg.sv
rtl/core/mdet_store.sv
rtl/core/mdet_engine.sv
rtl/core/matrix_determinant_top.sv
dv/matrix_determinant_checker.sv
dv/matrix_determinant_top_tb.sv
